// ===== rtl/core/bomt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bomt_pkg;

  // Contact table depth; a power of two no larger than the obstacle index range.
  localparam int unsigned MaxObstacles = 256;
  localparam int unsigned SlotW        = $clog2(MaxObstacles);

  localparam int unsigned CoordW = 32;  // Q16.16 centre and shift
  localparam int unsigned HalfW  = 31;  // unsigned Q15.16 half size
  localparam int unsigned TrigW  = 16;  // Q1.14 cos / sin
  localparam int unsigned ProdW  = HalfW + TrigW;
  localparam int unsigned RndW   = 32;  // rounded product, always below 2^32
  localparam int unsigned ExtW   = RndW + 1;
  localparam int unsigned BndW   = 33;  // saturated bound
  localparam int unsigned WideW  = 35;  // centre -/+ extent before saturation
  localparam int unsigned CandW  = BndW + 1;
  localparam int unsigned IdW    = 8;
  localparam int unsigned IgnW   = 4;

  typedef enum logic {
    KindLoad = 1'b0,
    KindTest = 1'b1
  } kind_e;

  // Ignore flag bit positions.
  localparam int unsigned IgnNegX = 0;
  localparam int unsigned IgnPosX = 1;
  localparam int unsigned IgnPosY = 2;
  localparam int unsigned IgnNegY = 3;

  // Round a Q1.14-scaled product to nearest, ties away from zero.
  function automatic logic [RndW-1:0] rnd14(input logic [ProdW-1:0] p);
    logic [ProdW:0] s;
    s = {1'b0, p} + (ProdW+1)'(8192);
    return s[RndW+13:14];
  endfunction

  function automatic logic signed [BndW-1:0] sat_bnd(input logic signed [WideW-1:0] v);
    if (v[WideW-1:BndW-1] == '0 || v[WideW-1:BndW-1] == '1) begin
      return v[BndW-1:0];
    end
    return v[WideW-1] ? {1'b1, {(BndW-1){1'b0}}} : {1'b0, {(BndW-1){1'b1}}};
  endfunction

  function automatic logic signed [CoordW-1:0] sat_out(input logic signed [CandW-1:0] v);
    if (v[CandW-1:CoordW-1] == '0 || v[CandW-1:CoordW-1] == '1) begin
      return v[CoordW-1:0];
    end
    return v[CandW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
  endfunction

  function automatic logic [CandW-1:0] cand_mag(input logic signed [CandW-1:0] v);
    return v[CandW-1] ? CandW'(-v) : CandW'(v);
  endfunction

  // Centre minus extent, saturated.
  function automatic logic signed [BndW-1:0] bnd_lo(input logic signed [CoordW-1:0] c,
                                                    input logic [ExtW-1:0] e);
    logic signed [WideW-1:0] d;
    d = WideW'(c) - $signed({{(WideW-ExtW){1'b0}}, e});
    return sat_bnd(d);
  endfunction

  // Centre plus extent, saturated.
  function automatic logic signed [BndW-1:0] bnd_hi(input logic signed [CoordW-1:0] c,
                                                    input logic [ExtW-1:0] e);
    logic signed [WideW-1:0] d;
    d = WideW'(c) + $signed({{(WideW-ExtW){1'b0}}, e});
    return sat_bnd(d);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/box_overlap_min_translation.sv =====
// Throughput: one item per cycle unless the output stalls. A load retires after
// stage 2 with no result; a test goes on through stages 3-5 and the output stage.
// The contact table takes one read and one write per cycle; a forwarding register
// covers a test that reads the entry written by the test just ahead of it.
// Reset clears all stage valids, the character bounds and the table's per-entry
// valid bits, so every contact reads as clear and items are taken at once.
`timescale 1ns / 1ps
`default_nettype none

module box_overlap_min_translation import bomt_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     kind_i,
  input  wire logic signed [CoordW-1:0] center_x_i,
  input  wire logic signed [CoordW-1:0] center_y_i,
  input  wire logic [HalfW-1:0]         half_width_i,
  input  wire logic [HalfW-1:0]         half_height_i,
  input  wire logic signed [TrigW-1:0]  cos_angle_i,
  input  wire logic signed [TrigW-1:0]  sin_angle_i,
  input  wire logic [IdW-1:0]           obstacle_id_i,
  input  wire logic [IgnW-1:0]          ignore_flags_i,
  input  wire logic                     is_zone_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [IdW-1:0]                result_obstacle_o,
  output logic                          overlapping_o,
  output logic signed [CoordW-1:0]      shift_x_o,
  output logic signed [CoordW-1:0]      shift_y_o,
  output logic                          contact_began_o,
  output logic                          contact_ended_o
);

  // ---------------------------------------------------------------------------
  // Stage advance: each stage loads when it is empty or its item moves on.
  // ---------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_v_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;
  logic s2_kind_q;

  assign rdy_out    = !out_v_q || out_ready_i;
  assign rdy5       = !s5_v_q || rdy_out;
  assign rdy4       = !s4_v_q || rdy5;
  assign rdy3       = !s3_v_q || rdy4;
  assign rdy2       = !s2_v_q || rdy3;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1) s1_v_q <= in_valid_i;
      if (rdy2) s2_v_q <= s1_v_q;
      // Loads retire here: only tests go on to stage 3.
      if (rdy3) s3_v_q <= s2_v_q && (s2_kind_q == KindTest);
      if (rdy4) s4_v_q <= s3_v_q;
      if (rdy5) s5_v_q <= s4_v_q;
      if (rdy_out) out_v_q <= s5_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the four extent products, one multiplier each.
  // ---------------------------------------------------------------------------
  logic [TrigW-1:0] in_ac, in_as;
  logic [ProdW-1:0] in_p_wc, in_p_hs, in_p_ws, in_p_hc;

  always_comb begin
    in_ac   = cos_angle_i[TrigW-1] ? TrigW'(-cos_angle_i) : TrigW'(cos_angle_i);
    in_as   = sin_angle_i[TrigW-1] ? TrigW'(-sin_angle_i) : TrigW'(sin_angle_i);
    in_p_wc = ProdW'(half_width_i) * ProdW'(in_ac);
    in_p_hs = ProdW'(half_height_i) * ProdW'(in_as);
    in_p_ws = ProdW'(half_width_i) * ProdW'(in_as);
    in_p_hc = ProdW'(half_height_i) * ProdW'(in_ac);
  end

  logic                     s1_kind_q;
  logic signed [CoordW-1:0] s1_cx_q, s1_cy_q;
  logic [ProdW-1:0]         s1_p_wc_q, s1_p_hs_q, s1_p_ws_q, s1_p_hc_q;
  logic [IdW-1:0]           s1_id_q;
  logic [IgnW-1:0]          s1_ign_q;
  logic                     s1_zone_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_kind_q <= kind_i;
      s1_cx_q   <= center_x_i;
      s1_cy_q   <= center_y_i;
      s1_p_wc_q <= in_p_wc;
      s1_p_hs_q <= in_p_hs;
      s1_p_ws_q <= in_p_ws;
      s1_p_hc_q <= in_p_hc;
      s1_id_q   <= obstacle_id_i;
      s1_ign_q  <= ignore_flags_i;
      s1_zone_q <= is_zone_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: round the products and sum into half extents.
  // ---------------------------------------------------------------------------
  logic signed [CoordW-1:0] s2_cx_q, s2_cy_q;
  logic [ExtW-1:0]          s2_ex_q, s2_ey_q;
  logic [IdW-1:0]           s2_id_q;
  logic [IgnW-1:0]          s2_ign_q;
  logic                     s2_zone_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_kind_q <= s1_kind_q;
      s2_cx_q   <= s1_cx_q;
      s2_cy_q   <= s1_cy_q;
      s2_ex_q   <= ExtW'(rnd14(s1_p_wc_q)) + ExtW'(rnd14(s1_p_hs_q));
      s2_ey_q   <= ExtW'(rnd14(s1_p_ws_q)) + ExtW'(rnd14(s1_p_hc_q));
      s2_id_q   <= s1_id_q;
      s2_ign_q  <= s1_ign_q;
      s2_zone_q <= s1_zone_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: saturated bounds. A load writes the character bounds as it
  // leaves stage 2, so every later test compares against them.
  // ---------------------------------------------------------------------------
  logic signed [BndW-1:0] s2_mnx, s2_mxx, s2_mny, s2_mxy;

  always_comb begin
    s2_mnx = bnd_lo(s2_cx_q, s2_ex_q);
    s2_mxx = bnd_hi(s2_cx_q, s2_ex_q);
    s2_mny = bnd_lo(s2_cy_q, s2_ey_q);
    s2_mxy = bnd_hi(s2_cy_q, s2_ey_q);
  end

  logic signed [BndW-1:0] chr_mnx_q, chr_mxx_q, chr_mny_q, chr_mxy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_mnx_q <= '0;
      chr_mxx_q <= '0;
      chr_mny_q <= '0;
      chr_mxy_q <= '0;
    end else if (rdy3 && s2_v_q && (s2_kind_q == KindLoad)) begin
      chr_mnx_q <= s2_mnx;
      chr_mxx_q <= s2_mxx;
      chr_mny_q <= s2_mny;
      chr_mxy_q <= s2_mxy;
    end
  end

  logic signed [BndW-1:0] s3_mnx_q, s3_mxx_q, s3_mny_q, s3_mxy_q;
  logic [IdW-1:0]         s3_id_q;
  logic [IgnW-1:0]        s3_ign_q;
  logic                   s3_zone_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_mnx_q  <= s2_mnx;
      s3_mxx_q  <= s2_mxx;
      s3_mny_q  <= s2_mny;
      s3_mxy_q  <= s2_mxy;
      s3_id_q   <= s2_id_q;
      s3_ign_q  <= s2_ign_q;
      s3_zone_q <= s2_zone_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: overlap test and the four candidate shifts; contact table read.
  // ---------------------------------------------------------------------------
  logic                    s3_hit;
  logic signed [CandW-1:0] s3_c0, s3_c1, s3_c2, s3_c3;

  always_comb begin
    s3_hit = !(s3_mnx_q > chr_mxx_q || chr_mnx_q > s3_mxx_q ||
               s3_mny_q > chr_mxy_q || chr_mny_q > s3_mxy_q);
    s3_c0  = CandW'(s3_mnx_q) - CandW'(chr_mxx_q);
    s3_c1  = CandW'(s3_mxx_q) - CandW'(chr_mnx_q);
    s3_c2  = CandW'(s3_mny_q) - CandW'(chr_mxy_q);
    s3_c3  = CandW'(s3_mxy_q) - CandW'(chr_mny_q);
  end

  logic                    s4_hit_q;
  logic signed [CandW-1:0] s4_c0_q, s4_c1_q, s4_c2_q, s4_c3_q;
  logic [IdW-1:0]          s4_id_q;
  logic [IgnW-1:0]         s4_ign_q;
  logic                    s4_zone_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      s4_hit_q  <= s3_hit;
      s4_c0_q   <= s3_c0;
      s4_c1_q   <= s3_c1;
      s4_c2_q   <= s3_c2;
      s4_c3_q   <= s3_c3;
      s4_id_q   <= s3_id_q;
      s4_ign_q  <= s3_ign_q;
      s4_zone_q <= s3_zone_q;
    end
  end

  // Contact table: synchronous read, write from stage 4.
  logic                    flag_mem_q [MaxObstacles];
  logic [MaxObstacles-1:0] flag_vld_q;
  logic                    rd_data_q, rd_vld_q;
  logic                    wr_en;
  logic [SlotW-1:0]        rd_addr, wr_addr;
  logic                    fwd_en_q, fwd_data_q;
  logic [SlotW-1:0]        fwd_addr_q;

  assign rd_addr = s3_id_q[SlotW-1:0];
  assign wr_addr = s4_id_q[SlotW-1:0];
  assign wr_en   = s4_v_q && rdy5;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      flag_mem_q[wr_addr] <= s4_hit_q;
    end
    if (rdy4) begin
      rd_data_q  <= flag_mem_q[rd_addr];
      rd_vld_q   <= flag_vld_q[rd_addr];
      fwd_data_q <= s4_hit_q;
      fwd_addr_q <= wr_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_vld_q <= '0;
      fwd_en_q   <= 1'b0;
    end else begin
      if (wr_en) flag_vld_q[wr_addr] <= 1'b1;
      // Remember the write that raced the read into stage 4.
      if (rdy4) fwd_en_q <= wr_en;
    end
  end

  // Flag before this item: forward the racing write, else the table word.
  logic s4_was;
  assign s4_was = (fwd_en_q && fwd_addr_q == wr_addr) ? fwd_data_q : (rd_vld_q & rd_data_q);

  // Drop a candidate only when it has the flagged sign; zero never drops.
  logic [3:0] s4_keep;

  always_comb begin
    s4_keep[0] = !((s4_ign_q[IgnNegX] && s4_c0_q < 0) || (s4_ign_q[IgnPosX] && s4_c0_q > 0));
    s4_keep[1] = !((s4_ign_q[IgnNegX] && s4_c1_q < 0) || (s4_ign_q[IgnPosX] && s4_c1_q > 0));
    s4_keep[2] = !((s4_ign_q[IgnPosY] && s4_c2_q > 0) || (s4_ign_q[IgnNegY] && s4_c2_q < 0));
    s4_keep[3] = !((s4_ign_q[IgnPosY] && s4_c3_q > 0) || (s4_ign_q[IgnNegY] && s4_c3_q < 0));
  end

  // ---------------------------------------------------------------------------
  // Stage 5: magnitudes, keep mask and contact events.
  // ---------------------------------------------------------------------------
  logic                    s5_hit_q, s5_began_q, s5_ended_q, s5_zone_q;
  logic [3:0]              s5_keep_q;
  logic [CandW-1:0]        s5_m0_q, s5_m1_q, s5_m2_q, s5_m3_q;
  logic signed [CandW-1:0] s5_c0_q, s5_c1_q, s5_c2_q, s5_c3_q;
  logic [IdW-1:0]          s5_id_q;

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      s5_hit_q   <= s4_hit_q;
      s5_began_q <= s4_hit_q && !s4_was;
      s5_ended_q <= !s4_hit_q && s4_was;
      s5_zone_q  <= s4_zone_q;
      s5_keep_q  <= s4_keep;
      s5_m0_q    <= cand_mag(s4_c0_q);
      s5_m1_q    <= cand_mag(s4_c1_q);
      s5_m2_q    <= cand_mag(s4_c2_q);
      s5_m3_q    <= cand_mag(s4_c3_q);
      s5_c0_q    <= s4_c0_q;
      s5_c1_q    <= s4_c1_q;
      s5_c2_q    <= s4_c2_q;
      s5_c3_q    <= s4_c3_q;
      s5_id_q    <= s4_id_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: pick the smallest kept candidate, earliest on a tie.
  // ---------------------------------------------------------------------------
  logic                    pick_x_first, pick_y_first, pick_x, any_x, any_y;
  logic [CandW-1:0]        best_mx, best_my;
  logic signed [CandW-1:0] best_cx, best_cy;
  logic signed [CoordW-1:0] sel_sx, sel_sy;

  always_comb begin
    pick_x_first = s5_keep_q[0] && (!s5_keep_q[1] || s5_m0_q <= s5_m1_q);
    pick_y_first = s5_keep_q[2] && (!s5_keep_q[3] || s5_m2_q <= s5_m3_q);
    any_x        = s5_keep_q[0] || s5_keep_q[1];
    any_y        = s5_keep_q[2] || s5_keep_q[3];
    best_mx      = pick_x_first ? s5_m0_q : s5_m1_q;
    best_cx      = pick_x_first ? s5_c0_q : s5_c1_q;
    best_my      = pick_y_first ? s5_m2_q : s5_m3_q;
    best_cy      = pick_y_first ? s5_c2_q : s5_c3_q;
    pick_x       = any_x && (!any_y || best_mx <= best_my);
    sel_sx       = '0;
    sel_sy       = '0;
    // Misses, zones and a fully filtered set all push by zero.
    if (s5_hit_q && !s5_zone_q) begin
      if (pick_x) begin
        sel_sx = sat_out(best_cx);
      end else if (any_y) begin
        sel_sy = sat_out(best_cy);
      end
    end
  end

  logic [IdW-1:0]           out_id_q;
  logic                     out_hit_q, out_began_q, out_ended_q;
  logic signed [CoordW-1:0] out_sx_q, out_sy_q;

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      out_id_q    <= s5_id_q;
      out_hit_q   <= s5_hit_q;
      out_sx_q    <= sel_sx;
      out_sy_q    <= sel_sy;
      out_began_q <= s5_began_q;
      out_ended_q <= s5_ended_q;
    end
  end

  assign out_valid_o       = out_v_q;
  assign result_obstacle_o = out_id_q;
  assign overlapping_o     = out_hit_q;
  assign shift_x_o         = out_sx_q;
  assign shift_y_o         = out_sy_q;
  assign contact_began_o   = out_began_q;
  assign contact_ended_o   = out_ended_q;

endmodule

`default_nettype wire
